// ----- hw/rtl/divider_and_programmable_timer_defines.svh -----
// ----------------------------------------------------------------------------
// Divider and programmable timer: assertion macros
// Shared concurrent assertion forms, sampled on clk; DPT_ASSERT is qualified by rst_n.
// ----------------------------------------------------------------------------
`ifndef DIVIDER_AND_PROGRAMMABLE_TIMER_DEFINES_SVH
`define DIVIDER_AND_PROGRAMMABLE_TIMER_DEFINES_SVH

// Checked only outside reset.
`define DPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/dpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Divider and programmable timer package
// Field widths, register indexes, the state record and the period table.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int unsigned CyclesW   = 8;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountdownW = 12;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_TIMER_ENABLE = 2'd0,
    CFG_CLOCK_SELECT = 2'd1,
    CFG_RELOAD_VALUE = 2'd2
  } dpt_cfg_idx_t;

  // Clock select codes.
  typedef enum logic [1:0] {
    SEL_1024 = 2'd0,
    SEL_16   = 2'd1,
    SEL_64   = 2'd2,
    SEL_256  = 2'd3
  } dpt_sel_t;

  localparam logic signed [CountdownW-1:0] CountdownReset = 12'sd1024;
  localparam logic signed [CountdownW:0]   CountdownFloor = -13'sd1024;
  localparam logic [ByteW-1:0]             CountMax       = 8'd255;

  typedef struct packed {
    logic [ByteW-1:0]             prescale;
    logic [ByteW-1:0]             divider;
    logic signed [CountdownW-1:0] countdown;
    logic [ByteW-1:0]             count;
  } dpt_state_t;

  typedef struct packed {
    logic             enable;
    dpt_sel_t         sel;
    logic [ByteW-1:0] reload;
  } dpt_cfg_t;

  // Timer period in machine cycles for each select code.
  function automatic logic [CountdownW-1:0] period_of(dpt_sel_t sel);
    logic [CountdownW-1:0] p;
    case (sel)
      SEL_1024: p = 12'd1024;
      SEL_16:   p = 12'd16;
      SEL_64:   p = 12'd64;
      SEL_256:  p = 12'd256;
      default:  p = 12'd1024;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/dpt_step.sv -----
// ----------------------------------------------------------------------------
// Divider and timer next-state logic
// One update of divider, countdown and timer counter for one beat.
// ----------------------------------------------------------------------------
module dpt_step (
  input  dpt_pkg::dpt_state_t         cur,
  input  dpt_pkg::dpt_cfg_t           cfg,
  input  logic [dpt_pkg::CyclesW-1:0] cycles,
  output dpt_pkg::dpt_state_t         nxt,
  output logic                        irq
);
  import dpt_pkg::*;

  logic [ByteW:0]               pre_sum;
  logic signed [CountdownW:0]   cd_sub;
  logic signed [CountdownW:0]   cd_add;
  logic signed [CountdownW:0]   cd_new;
  logic                         expire;

  always_comb begin
    // Prescaler stays below 256, so one carry out steps the divider.
    pre_sum = {1'b0, cur.prescale} + {1'b0, cycles};

    cd_sub = {cur.countdown[CountdownW-1], cur.countdown}
             - $signed({{(CountdownW+1-CyclesW){1'b0}}, cycles});
    expire = (cd_sub <= 0);
    cd_add = cd_sub + $signed({1'b0, period_of(cfg.sel)});
    cd_new = expire ? cd_add : cd_sub;
    if (cd_new < CountdownFloor) begin
      cd_new = CountdownFloor;
    end

    nxt          = cur;
    irq          = 1'b0;
    nxt.prescale = pre_sum[ByteW-1:0];
    nxt.divider  = pre_sum[ByteW] ? cur.divider + 8'd1 : cur.divider;
    if (cfg.enable) begin
      nxt.countdown = cd_new[CountdownW-1:0];
      if (expire) begin
        if (cur.count == CountMax) begin
          nxt.count = cfg.reload;
          irq       = 1'b1;
        end else begin
          nxt.count = cur.count + 8'd1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/divider_and_programmable_timer.sv -----
// ----------------------------------------------------------------------------
// Divider and programmable timer
// Output: a result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while out_tready is high; the single output register frees whenever
// out_tready is high, so input and output proceed together.
// Reset: synchronous, active low; clears the configuration, output valid, prescaler,
// divider and counter, and loads the countdown with 1024.
// ----------------------------------------------------------------------------
module divider_and_programmable_timer (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [dpt_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [dpt_pkg::CfgDataW-1:0]  cfg_wdata,
  // Input stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dpt_pkg::InDataW-1:0]   in_tdata,   // [7:0] elapsed_cycles
  // Result stream.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dpt_pkg::OutDataW-1:0]  out_tdata,  // [7:0] divider_value,
                                                    // [15:8] timer_value
  output logic                          out_tuser   // [0] timer_irq
);
  import dpt_pkg::*;

  dpt_state_t             state_r;
  dpt_state_t             state_nxt;
  dpt_cfg_t               cfg_r;
  logic                   irq_nxt;
  logic                   out_valid_r;
  logic [OutDataW-1:0]    out_data_r;
  logic                   out_irq_r;
  logic                   in_beat;

  // The output register is the only buffer: a new beat enters whenever it is
  // empty or being drained in the same cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  // All arithmetic for a beat happens between state_r and the output register.
  dpt_step u_step (
    .cur    (state_r),
    .cfg    (cfg_r),
    .cycles (in_tdata[CyclesW-1:0]),
    .nxt    (state_nxt),
    .irq    (irq_nxt)
  );

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b0;
      cfg_r.sel    <= SEL_1024;
      cfg_r.reload <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TIMER_ENABLE: cfg_r.enable <= cfg_wdata[0];
        CFG_CLOCK_SELECT: cfg_r.sel    <= dpt_sel_t'(cfg_wdata[1:0]);
        CFG_RELOAD_VALUE: cfg_r.reload <= cfg_wdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Timer state advances once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.prescale  <= '0;
      state_r.divider   <= '0;
      state_r.countdown <= CountdownReset;
      state_r.count     <= '0;
    end else if (in_beat) begin
      state_r <= state_nxt;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload holds the values after this beat's update.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_data_r <= {state_nxt.count, state_nxt.divider};
      out_irq_r  <= irq_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_irq_r;

endmodule

// ----- hw/rtl/dpt_checker.sv -----
// ----------------------------------------------------------------------------
// Divider and programmable timer port checker
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`include "divider_and_programmable_timer_defines.svh"

module dpt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [dpt_pkg::OutDataW-1:0]  out_tdata,
  input logic                          out_tuser
);

  // Reset empties the output register.
  `DPT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")

  // Every accepted input beat yields a result in the next cycle.
  `DPT_ASSERT(a_beat_result, (in_tvalid && in_tready) |=> out_tvalid, "result beat missing")

  // A draining output never blocks the input side.
  `DPT_ASSERT(a_no_stall, out_tready |-> in_tready, "input stalled while output drains")

  // A stalled result holds its payload.
  `DPT_ASSERT(a_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result changed")

endmodule

bind divider_and_programmable_timer dpt_checker u_dpt_checker (.*);
